/* hdl/rpt_pkg.sv */
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants of the pattern tokenizer
// token codes, lexing modes, halt codes, character codes and queue sizing
// ----------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

  // token codes
  typedef enum logic [4:0] {
    K_LPAREN   = 5'd0,
    K_RPAREN   = 5'd1,
    K_LBRACKET = 5'd2,
    K_RBRACKET = 5'd3,
    K_LBRACE   = 5'd4,
    K_RBRACE   = 5'd5,
    K_STAR     = 5'd6,
    K_PLUS     = 5'd7,
    K_QUESTION = 5'd8,
    K_COMMA    = 5'd9,
    K_UNION    = 5'd10,
    K_MINUS    = 5'd11,
    K_END      = 5'd12,
    K_ESC      = 5'd13,
    K_CLASS    = 5'd14,
    K_SYMBOL   = 5'd15,
    K_NUMBER   = 5'd16
  } kind_t;

  // lexing modes
  typedef enum logic [1:0] {
    MODE_GEN   = 2'd0,
    MODE_CLASS = 2'd1,
    MODE_RANGE = 2'd2
  } mode_t;

  // run state: running, ended, stopped by an error
  typedef enum logic [1:0] {
    HALT_RUN    = 2'd0,
    HALT_END    = 2'd1,
    HALT_BADTOK = 2'd2,
    HALT_BADSYM = 2'd3
  } halt_t;

  // status reported with each token
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_WARN   = 2'd1,
    ST_BADTOK = 2'd2,
    ST_BADSYM = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [1:0] CFG_IGNORE_BAD_ESC = 2'd0;
  localparam logic [1:0] CFG_STRAY_AS_ESC   = 2'd1;
  localparam logic [1:0] CFG_SKIP_NONPRINT  = 2'd2;

  // class codes
  localparam logic [7:0] CLS_SPACE = 8'd0;
  localparam logic [7:0] CLS_DIGIT = 8'd1;
  localparam logic [7:0] CLS_WORD  = 8'd2;

  // character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LOWER_D   = 8'h64;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_S   = 8'h73;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_W   = 8'h77;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sym;
    logic [15:0] num;
    logic [15:0] bpos;
    logic [15:0] epos;
    status_t     status;
  } token_t;

  // tokens caused by one byte
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } packet_t;

endpackage

`default_nettype wire

/* hdl/regex_pattern_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// regex_pattern_tokenizer_unit: regular expression pattern lexer
// turns a stream of pattern bytes into tokens with begin and end positions
// ----------------------------------------------------------------------------
// a byte's first token reaches the output through the packet queue and the output register
// throughput: one byte per cycle unless the queue is full; a byte with two tokens holds
//   the output for both, and the four-entry packet queue absorbs the difference
// reset (rst, synchronous): general mode, positions, number, warning and
//   halt state cleared, configuration registers zero, queue and output empty
`default_nettype none

module regex_pattern_tokenizer_unit #(
  parameter int POS_WIDTH = 16,
  parameter int NUM_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,

  // pattern byte channel
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [7:0]  char_code,

  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data,

  // token channel
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [4:0]       token_kind,
  output logic [7:0]       symbol_value,
  output logic [15:0]      number_value,
  output logic [15:0]      begin_pos,
  output logic [15:0]      end_pos,
  output logic [1:0]       lex_status,
  output logic             last_of_run
);

  // front to queue
  logic              push;
  rpt_pkg::packet_t  push_pkt;
  logic              q_full;

  // queue to back
  rpt_pkg::packet_t  head;
  logic              q_nonempty;
  logic              pop;

  rpt_pkg::token_t   token;

  // front: holds the lexing state and the configuration bits, decodes each
  // byte combinationally and pushes a packet of zero, one or two tokens;
  // it stalls the byte channel only when the queue is full
  rpt_front #(
    .POS_WIDTH (POS_WIDTH),
    .NUM_WIDTH (NUM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_pkt   (push_pkt)
  );

  // queue: decouples byte acceptance from token delivery
  rpt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // back: registered output, one token transaction per cycle while the receiver
  // does not stall, marks the final token of each byte
  rpt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .nonempty    (q_nonempty),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token),
    .last        (last_of_run)
  );

  assign token_kind   = token.kind;
  assign symbol_value = token.sym;
  assign number_value = token.num;
  assign begin_pos    = token.bpos;
  assign end_pos      = token.epos;
  assign lex_status   = token.status;

endmodule

`default_nettype wire

/* hdl/rpt_front.sv */
// ----------------------------------------------------------------------------
// rpt_front: lexer front end
// takes one byte per cycle unless the queue is full, keeps lexing state and builds token packets
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_front #(
  parameter int POS_WIDTH = 16,
  parameter int NUM_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             char_valid,
  output logic                  char_stall,
  input  wire logic [7:0]       char_code,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic             cfg_data,
  input  wire logic             q_full,
  output logic                  push,
  output rpt_pkg::packet_t      push_pkt
);

  localparam logic [NUM_WIDTH-1:0] NUM_MAX = {NUM_WIDTH{1'b1}};

  // configuration
  logic ignore_bad_escape;
  logic stray_closer_as_escaped;
  logic skip_nonprintable;

  // lexing state
  rpt_pkg::mode_t         lex_mode, lex_mode_next;
  logic                   escape_pending, escape_pending_next;
  logic                   number_active, number_active_next;
  logic [NUM_WIDTH-1:0]   number_accum, number_accum_next;
  logic [POS_WIDTH-1:0]   token_start, token_start_next;
  logic [POS_WIDTH-1:0]   byte_position;
  logic                   warning_seen, warning_seen_next;
  rpt_pkg::halt_t         halted, halted_next;

  logic                   accept;
  logic                   run;
  logic [POS_WIDTH-1:0]   pos_end;
  logic [15:0]            p16, e16, s16;
  logic                   in_class;

  // plain lexing of the byte
  logic                   pl_v;
  rpt_pkg::kind_t         pl_kind;
  logic [7:0]             pl_sym;
  rpt_pkg::mode_t         pl_mode;
  logic                   pl_esc;
  logic                   pl_warn;
  rpt_pkg::halt_t         pl_halt;
  logic                   pl_stray;

  // escape lookup
  logic                   esc_known;
  rpt_pkg::kind_t         esc_kind;
  logic [7:0]             esc_val;

  // number arithmetic
  logic                   is_digit;
  logic [3:0]             digit;
  logic [NUM_WIDTH+3:0]   acc_times_ten;

  logic                   num_v;
  rpt_pkg::token_t        num_tok;
  logic                   main_v;
  rpt_pkg::token_t        main_tok;

  function automatic logic [15:0] to16(input logic [POS_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [15:0] num16(input logic [NUM_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  assign accept     = char_valid && !char_stall;
  assign char_stall = q_full;
  assign cfg_ready  = 1'b1;
  assign run        = accept && (halted == rpt_pkg::HALT_RUN);
  assign pos_end    = byte_position + POS_WIDTH'(1);
  assign p16        = to16(byte_position);
  assign e16        = to16(pos_end);
  assign s16        = to16(token_start);
  assign in_class   = (lex_mode == rpt_pkg::MODE_CLASS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_bad_escape       <= 1'b0;
      stray_closer_as_escaped <= 1'b0;
      skip_nonprintable       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpt_pkg::CFG_IGNORE_BAD_ESC: ignore_bad_escape       <= cfg_data;
        rpt_pkg::CFG_STRAY_AS_ESC:   stray_closer_as_escaped <= cfg_data;
        rpt_pkg::CFG_SKIP_NONPRINT:  skip_nonprintable       <= cfg_data;
        default: ;
      endcase
    end
  end

  // plain lexing, shared by general and class modes and the range fallback
  always_comb begin
    pl_v     = 1'b0;
    pl_kind  = rpt_pkg::K_SYMBOL;
    pl_sym   = 8'd0;
    pl_mode  = (lex_mode == rpt_pkg::MODE_RANGE) ? rpt_pkg::MODE_GEN : lex_mode;
    pl_esc   = 1'b0;
    pl_warn  = 1'b0;
    pl_halt  = rpt_pkg::HALT_RUN;
    pl_stray = 1'b0;
    if (char_code == rpt_pkg::CH_NUL) begin
      pl_v    = 1'b1;
      pl_kind = rpt_pkg::K_END;
      pl_mode = rpt_pkg::MODE_GEN;
      pl_halt = rpt_pkg::HALT_END;
    end else if (char_code == rpt_pkg::CH_BACKSLASH) begin
      pl_esc = 1'b1;
    end else if (char_code < rpt_pkg::CH_PRINT_LO || char_code > rpt_pkg::CH_PRINT_HI) begin
      if (skip_nonprintable) begin
        pl_warn = 1'b1;
      end else begin
        pl_v    = 1'b1;
        pl_kind = rpt_pkg::K_END;
        pl_halt = rpt_pkg::HALT_BADSYM;
      end
    end else begin
      pl_v = 1'b1;
      unique case (char_code)
        rpt_pkg::CH_STAR:     pl_kind = rpt_pkg::K_STAR;
        rpt_pkg::CH_PLUS:     pl_kind = rpt_pkg::K_PLUS;
        rpt_pkg::CH_QUESTION: pl_kind = rpt_pkg::K_QUESTION;
        rpt_pkg::CH_BAR:      pl_kind = rpt_pkg::K_UNION;
        rpt_pkg::CH_LPAREN:   pl_kind = rpt_pkg::K_LPAREN;
        rpt_pkg::CH_MINUS: begin
          if (in_class) begin
            pl_kind = rpt_pkg::K_MINUS;
          end else begin
            pl_sym = char_code;
          end
        end
        rpt_pkg::CH_LBRACKET: begin
          pl_kind = rpt_pkg::K_LBRACKET;
          if (!in_class) begin
            pl_mode = rpt_pkg::MODE_CLASS;
          end
        end
        rpt_pkg::CH_RBRACKET: begin
          pl_kind = rpt_pkg::K_RBRACKET;
          if (in_class) begin
            pl_mode = rpt_pkg::MODE_GEN;
          end else begin
            pl_stray = 1'b1;
          end
        end
        rpt_pkg::CH_RPAREN: begin
          pl_kind  = rpt_pkg::K_RPAREN;
          pl_stray = in_class;
        end
        rpt_pkg::CH_LBRACE: begin
          pl_kind = rpt_pkg::K_LBRACE;
          if (in_class) begin
            pl_stray = 1'b1;
          end else begin
            pl_mode = rpt_pkg::MODE_RANGE;
          end
        end
        rpt_pkg::CH_RBRACE: begin
          pl_kind  = rpt_pkg::K_RBRACE;
          pl_stray = 1'b1;
        end
        default: pl_sym = char_code;
      endcase
      if (pl_stray && stray_closer_as_escaped) begin
        pl_kind = rpt_pkg::K_ESC;
        pl_sym  = char_code;
        pl_warn = 1'b1;
      end
    end
  end

  // escape table
  always_comb begin
    esc_known = 1'b1;
    esc_kind  = rpt_pkg::K_ESC;
    esc_val   = char_code;
    unique case (char_code)
      rpt_pkg::CH_BACKSLASH, rpt_pkg::CH_LBRACKET, rpt_pkg::CH_RBRACKET,
      rpt_pkg::CH_LPAREN, rpt_pkg::CH_RPAREN, rpt_pkg::CH_LBRACE,
      rpt_pkg::CH_RBRACE, rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS,
      rpt_pkg::CH_QUESTION, rpt_pkg::CH_BAR: ;
      rpt_pkg::CH_LOWER_T: esc_val = rpt_pkg::CH_TAB;
      rpt_pkg::CH_LOWER_N: esc_val = rpt_pkg::CH_NEWLINE;
      rpt_pkg::CH_MINUS:   esc_known = in_class;
      rpt_pkg::CH_LOWER_S: begin
        esc_kind = rpt_pkg::K_CLASS;
        esc_val  = rpt_pkg::CLS_SPACE;
      end
      rpt_pkg::CH_LOWER_D: begin
        esc_kind = rpt_pkg::K_CLASS;
        esc_val  = rpt_pkg::CLS_DIGIT;
      end
      rpt_pkg::CH_LOWER_W: begin
        esc_kind = rpt_pkg::K_CLASS;
        esc_val  = rpt_pkg::CLS_WORD;
      end
      default: esc_known = 1'b0;
    endcase
  end

  // decimal accumulation: acc * 10 + digit as two shifts and two adds
  assign is_digit      = (char_code >= rpt_pkg::CH_ZERO) && (char_code <= rpt_pkg::CH_NINE);
  assign digit         = 4'(char_code - rpt_pkg::CH_ZERO);
  assign acc_times_ten = ((NUM_WIDTH+4)'(number_accum) << 3)
                       + ((NUM_WIDTH+4)'(number_accum) << 1)
                       + (NUM_WIDTH+4)'(digit);

  always_comb begin
    lex_mode_next       = lex_mode;
    escape_pending_next = escape_pending;
    number_active_next  = number_active;
    number_accum_next   = number_accum;
    token_start_next    = token_start;
    warning_seen_next   = warning_seen;
    halted_next         = halted;
    num_v               = 1'b0;
    num_tok             = '{kind: rpt_pkg::K_NUMBER, sym: 8'd0, num: num16(number_accum),
                            bpos: s16, epos: p16,
                            status: warning_seen ? rpt_pkg::ST_WARN : rpt_pkg::ST_OK};
    main_v              = 1'b0;
    main_tok            = '{kind: pl_kind, sym: pl_sym, num: 16'd0, bpos: p16, epos: e16,
                            status: rpt_pkg::ST_OK};

    if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (char_code == rpt_pkg::CH_NUL) begin
        main_v        = 1'b1;
        main_tok.kind = rpt_pkg::K_END;
        main_tok.sym  = 8'd0;
        if (ignore_bad_escape) begin
          warning_seen_next = 1'b1;
          lex_mode_next     = rpt_pkg::MODE_GEN;
          halted_next       = rpt_pkg::HALT_END;
          main_tok.status   = rpt_pkg::ST_WARN;
        end else begin
          halted_next     = rpt_pkg::HALT_BADTOK;
          main_tok.bpos   = s16;
          main_tok.epos   = p16;
          main_tok.status = rpt_pkg::ST_BADTOK;
        end
      end else if (esc_known) begin
        main_v          = 1'b1;
        main_tok.kind   = esc_kind;
        main_tok.sym    = esc_val;
        main_tok.bpos   = s16;
        main_tok.status = warning_seen ? rpt_pkg::ST_WARN : rpt_pkg::ST_OK;
      end else if (ignore_bad_escape) begin
        warning_seen_next = 1'b1;
      end else begin
        main_v          = 1'b1;
        main_tok.kind   = rpt_pkg::K_END;
        main_tok.sym    = 8'd0;
        main_tok.bpos   = s16;
        main_tok.status = rpt_pkg::ST_BADTOK;
        halted_next     = rpt_pkg::HALT_BADTOK;
      end
    end else if (lex_mode == rpt_pkg::MODE_RANGE && is_digit) begin
      number_active_next = 1'b1;
      if (!number_active) begin
        token_start_next  = byte_position;
        number_accum_next = NUM_WIDTH'(digit);
      end else if (|acc_times_ten[NUM_WIDTH+3:NUM_WIDTH]) begin
        number_accum_next = NUM_MAX;
      end else begin
        number_accum_next = acc_times_ten[NUM_WIDTH-1:0];
      end
    end else begin
      if (lex_mode == rpt_pkg::MODE_RANGE) begin
        // a number closes at the first non-digit byte
        num_v              = number_active;
        number_active_next = 1'b0;
        number_accum_next  = '0;
      end
      if (lex_mode == rpt_pkg::MODE_RANGE && char_code == rpt_pkg::CH_RBRACE) begin
        main_v          = 1'b1;
        main_tok.kind   = rpt_pkg::K_RBRACE;
        main_tok.sym    = 8'd0;
        main_tok.status = warning_seen ? rpt_pkg::ST_WARN : rpt_pkg::ST_OK;
        lex_mode_next   = rpt_pkg::MODE_GEN;
      end else if (lex_mode == rpt_pkg::MODE_RANGE && char_code == rpt_pkg::CH_COMMA) begin
        main_v          = 1'b1;
        main_tok.kind   = rpt_pkg::K_COMMA;
        main_tok.sym    = 8'd0;
        main_tok.status = warning_seen ? rpt_pkg::ST_WARN : rpt_pkg::ST_OK;
      end else begin
        main_v            = pl_v;
        lex_mode_next     = pl_mode;
        warning_seen_next = warning_seen | pl_warn;
        halted_next       = pl_halt;
        if (pl_esc) begin
          escape_pending_next = 1'b1;
          token_start_next    = byte_position;
        end
        if (pl_halt == rpt_pkg::HALT_BADSYM) begin
          main_tok.status = rpt_pkg::ST_BADSYM;
        end else begin
          main_tok.status = (warning_seen | pl_warn) ? rpt_pkg::ST_WARN : rpt_pkg::ST_OK;
        end
      end
    end
  end

  always_comb begin
    push          = run && (num_v || main_v);
    push_pkt.two  = num_v && main_v;
    push_pkt.tok0 = num_v ? num_tok : main_tok;
    push_pkt.tok1 = main_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= rpt_pkg::MODE_GEN;
      escape_pending <= 1'b0;
      number_active  <= 1'b0;
      number_accum   <= '0;
      token_start    <= '0;
      byte_position  <= '0;
      warning_seen   <= 1'b0;
      halted         <= rpt_pkg::HALT_RUN;
    end else if (run) begin
      lex_mode       <= lex_mode_next;
      escape_pending <= escape_pending_next;
      number_active  <= number_active_next;
      number_accum   <= number_accum_next;
      token_start    <= token_start_next;
      byte_position  <= pos_end;
      warning_seen   <= warning_seen_next;
      halted         <= halted_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/rpt_queue.sv */
// ----------------------------------------------------------------------------
// rpt_queue: token packet queue
// small first-in first-out store between the lexer front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rpt_pkg::packet_t  push_pkt,
  input  wire logic              pop,
  output rpt_pkg::packet_t       head,
  output logic                   full,
  output logic                   nonempty
);

  rpt_pkg::packet_t                entry [rpt_pkg::QDEPTH];
  logic [rpt_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rpt_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rpt_pkg::QCNT_W-1:0]      count;

  assign full     = (count == rpt_pkg::QCNT_W'(rpt_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rpt_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rpt_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rpt_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rpt_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= rpt_pkg::QCNT_W'(rpt_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> !pop)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + rpt_pkg::QCNT_W'(1)))
    else $error("count did not follow push");
`endif

endmodule

`default_nettype wire

/* hdl/rpt_back.sv */
// ----------------------------------------------------------------------------
// rpt_back: token output stage
// unpacks queued packets into single token transactions on the output
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rpt_pkg::packet_t  head,
  input  wire logic              nonempty,
  output logic                   pop,
  output logic                   token_valid,
  input  wire logic              token_stall,
  output rpt_pkg::token_t        token,
  output logic                   last
);

  rpt_pkg::packet_t cur;
  logic             cur_valid;
  logic             phase;
  logic             fire;
  logic             more;

  assign fire        = cur_valid && !token_stall;
  assign more        = !phase && cur.two;
  assign pop         = nonempty && (!cur_valid || (fire && !more));
  assign token_valid = cur_valid;
  assign token       = phase ? cur.tok1 : cur.tok0;
  assign last        = phase || !cur.two;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (fire) begin
      if (more) begin
        phase <= 1'b1;
      end else begin
        cur_valid <= 1'b0;
        phase     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* bench/rpt_token_checker.sv */
// ----------------------------------------------------------------------------
// rpt_token_checker: token scoreboard for the pattern tokenizer
// follows configuration writes and accepted pattern bytes, works out the
// tokens each byte must produce, and compares every accepted token in order
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_token_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  input  wire logic        char_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        token_valid,
  input  wire logic        token_stall,
  input  wire logic [4:0]  token_kind,
  input  wire logic [7:0]  symbol_value,
  input  wire logic [15:0] number_value,
  input  wire logic [15:0] begin_pos,
  input  wire logic [15:0] end_pos,
  input  wire logic [1:0]  lex_status,
  input  wire logic        last_of_run,
  output int               mismatches,
  output int               outstanding
);
  import rpt_pkg::*;

  localparam logic [15:0] NUM_SAT = 16'hFFFF;

  typedef struct packed {
    token_t tok;
    logic   last;
  } expected_t;

  expected_t   expected_tokens[$];
  expected_t   byte_tokens[2];
  int          byte_token_count;

  // configuration and lexer state copies
  logic        ignore_bad_esc;
  logic        stray_as_esc;
  logic        skip_nonprint;
  mode_t       lex_mode;
  logic        esc_pending;
  logic        num_active;
  logic [15:0] num_accum;
  logic [15:0] tok_start;
  logic [15:0] byte_pos;
  logic        warned;
  halt_t       halt;

  function automatic void add_token(input kind_t k, input logic [7:0] s,
                                    input logic [15:0] n, input logic [15:0] b,
                                    input logic [15:0] e);
    expected_t t;
    t.tok.kind = k;
    t.tok.sym  = s;
    t.tok.num  = n;
    t.tok.bpos = b;
    t.tok.epos = e;
    if (halt == HALT_BADTOK) t.tok.status = ST_BADTOK;
    else if (halt == HALT_BADSYM) t.tok.status = ST_BADSYM;
    else if (warned) t.tok.status = ST_WARN;
    else t.tok.status = ST_OK;
    t.last = 1'b0;
    byte_tokens[byte_token_count] = t;
    byte_token_count++;
  endfunction

  function automatic void end_pattern(input logic [15:0] p);
    lex_mode = MODE_GEN;
    halt = HALT_END;
    add_token(K_END, 8'd0, 16'd0, p, p + 16'd1);
  endfunction

  function automatic void raise_error(input halt_t code, input logic [15:0] b,
                                      input logic [15:0] e);
    halt = code;
    add_token(K_END, 8'd0, 16'd0, b, e);
  endfunction

  function automatic logic escape_lookup(input logic [7:0] c, input logic in_class,
                                         output kind_t k, output logic [7:0] v);
    logic known;
    k = K_ESC;
    v = c;
    known = 1'b1;
    case (c)
      CH_BACKSLASH, CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN,
      CH_LBRACE, CH_RBRACE, CH_STAR, CH_PLUS, CH_QUESTION, CH_BAR: ;
      CH_LOWER_T: v = CH_TAB;
      CH_LOWER_N: v = CH_NEWLINE;
      CH_MINUS:   known = in_class;
      CH_LOWER_S: begin k = K_CLASS; v = CLS_SPACE; end
      CH_LOWER_D: begin k = K_CLASS; v = CLS_DIGIT; end
      CH_LOWER_W: begin k = K_CLASS; v = CLS_WORD; end
      default:    known = 1'b0;
    endcase
    return known;
  endfunction

  function automatic void resolve_escape(input logic [7:0] c, input logic [15:0] p,
                                         input logic in_class);
    kind_t      k;
    logic [7:0] v;
    if (c == CH_NUL) begin
      if (ignore_bad_esc) begin
        warned = 1'b1;
        end_pattern(p);
      end else begin
        raise_error(HALT_BADTOK, tok_start, p);
      end
    end else if (escape_lookup(c, in_class, k, v)) begin
      add_token(k, v, 16'd0, tok_start, p + 16'd1);
    end else if (ignore_bad_esc) begin
      warned = 1'b1;
    end else begin
      raise_error(HALT_BADTOK, tok_start, p + 16'd1);
    end
  endfunction

  function automatic void stray_closer(input logic [7:0] c, input kind_t plain,
                                       input logic [15:0] p);
    if (stray_as_esc) begin
      warned = 1'b1;
      add_token(K_ESC, c, 16'd0, p, p + 16'd1);
    end else begin
      add_token(plain, 8'd0, 16'd0, p, p + 16'd1);
    end
  endfunction

  function automatic void lex_general(input logic [7:0] c, input logic [15:0] p,
                                      input logic in_class);
    logic [15:0] e;
    logic        done;
    e = p + 16'd1;
    done = 1'b1;
    if (c == CH_NUL) begin
      end_pattern(p);
    end else if (c == CH_BACKSLASH) begin
      esc_pending = 1'b1;
      tok_start = p;
    end else if (c < CH_PRINT_LO || c > CH_PRINT_HI) begin
      if (skip_nonprint) warned = 1'b1;
      else raise_error(HALT_BADSYM, p, e);
    end else if (in_class) begin
      case (c)
        CH_MINUS:    add_token(K_MINUS, 8'd0, 16'd0, p, e);
        CH_RBRACKET: begin
          lex_mode = MODE_GEN;
          add_token(K_RBRACKET, 8'd0, 16'd0, p, e);
        end
        CH_LBRACKET: add_token(K_LBRACKET, 8'd0, 16'd0, p, e);
        CH_LPAREN:   add_token(K_LPAREN, 8'd0, 16'd0, p, e);
        CH_RPAREN:   stray_closer(c, K_RPAREN, p);
        CH_LBRACE:   stray_closer(c, K_LBRACE, p);
        CH_RBRACE:   stray_closer(c, K_RBRACE, p);
        default:     done = 1'b0;
      endcase
    end else begin
      case (c)
        CH_LBRACKET: begin
          lex_mode = MODE_CLASS;
          add_token(K_LBRACKET, 8'd0, 16'd0, p, e);
        end
        CH_RBRACKET: stray_closer(c, K_RBRACKET, p);
        CH_LPAREN:   add_token(K_LPAREN, 8'd0, 16'd0, p, e);
        CH_RPAREN:   add_token(K_RPAREN, 8'd0, 16'd0, p, e);
        CH_LBRACE: begin
          lex_mode = MODE_RANGE;
          add_token(K_LBRACE, 8'd0, 16'd0, p, e);
        end
        CH_RBRACE:   stray_closer(c, K_RBRACE, p);
        default:     done = 1'b0;
      endcase
    end
    if (!done) begin
      case (c)
        CH_STAR:     add_token(K_STAR, 8'd0, 16'd0, p, e);
        CH_PLUS:     add_token(K_PLUS, 8'd0, 16'd0, p, e);
        CH_QUESTION: add_token(K_QUESTION, 8'd0, 16'd0, p, e);
        CH_BAR:      add_token(K_UNION, 8'd0, 16'd0, p, e);
        default:     add_token(K_SYMBOL, c, 16'd0, p, e);
      endcase
    end
  endfunction

  function automatic void lex_range(input logic [7:0] c, input logic [15:0] p);
    logic [31:0] grown;
    logic [7:0]  digit;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = c - CH_ZERO;
      if (!num_active) begin
        num_active = 1'b1;
        tok_start = p;
        num_accum = {8'd0, digit};
      end else begin
        grown = 32'(num_accum) * 32'd10 + 32'(digit);
        num_accum = (grown > 32'(NUM_SAT)) ? NUM_SAT : grown[15:0];
      end
    end else begin
      // a non-digit closes the number, then is lexed on its own
      if (num_active) begin
        num_active = 1'b0;
        add_token(K_NUMBER, 8'd0, num_accum, tok_start, p);
        num_accum = 16'd0;
      end
      if (c == CH_NUL) begin
        end_pattern(p);
      end else if (c == CH_RBRACE) begin
        lex_mode = MODE_GEN;
        add_token(K_RBRACE, 8'd0, 16'd0, p, p + 16'd1);
      end else if (c == CH_COMMA) begin
        add_token(K_COMMA, 8'd0, 16'd0, p, p + 16'd1);
      end else begin
        lex_mode = MODE_GEN;
        lex_general(c, p, 1'b0);
      end
    end
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    logic [15:0] p;
    expected_t   t;
    byte_token_count = 0;
    if (halt != HALT_RUN) return;
    p = byte_pos;
    byte_pos = byte_pos + 16'd1;
    if (esc_pending) begin
      esc_pending = 1'b0;
      resolve_escape(c, p, lex_mode == MODE_CLASS);
    end else if (lex_mode == MODE_RANGE) begin
      lex_range(c, p);
    end else begin
      lex_general(c, p, lex_mode == MODE_CLASS);
    end
    for (int i = 0; i < byte_token_count; i++) begin
      t = byte_tokens[i];
      t.last = (i == byte_token_count - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  always @(posedge clk) begin : watch
    expected_t want;
    if (rst) begin
      ignore_bad_esc = 1'b0;
      stray_as_esc = 1'b0;
      skip_nonprint = 1'b0;
      lex_mode = MODE_GEN;
      esc_pending = 1'b0;
      num_active = 1'b0;
      num_accum = 16'd0;
      tok_start = 16'd0;
      byte_pos = 16'd0;
      warned = 1'b0;
      halt = HALT_RUN;
      expected_tokens.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IGNORE_BAD_ESC: ignore_bad_esc = cfg_data;
          CFG_STRAY_AS_ESC:   stray_as_esc = cfg_data;
          CFG_SKIP_NONPRINT:  skip_nonprint = cfg_data;
          default: ;
        endcase
      end
      if (char_valid && !char_stall) lex_byte(char_code);
      if (token_valid && !token_stall) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected token: kind %0d sym %0d num %0d pos %0d..%0d st %0d last %0b",
                     token_kind, symbol_value, number_value, begin_pos, end_pos,
                     lex_status, last_of_run);
        end else begin
          want = expected_tokens.pop_front();
          if (want.tok.kind != token_kind || want.tok.sym != symbol_value ||
              want.tok.num != number_value || want.tok.bpos != begin_pos ||
              want.tok.epos != end_pos || want.tok.status != lex_status ||
              want.last != last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("token mismatch: want kind %0d sym %0d num %0d pos %0d..%0d",
                       want.tok.kind, want.tok.sym, want.tok.num, want.tok.bpos,
                       want.tok.epos, " st %0d last %0b", want.tok.status, want.last,
                       "; got kind %0d sym %0d num %0d pos %0d..%0d", token_kind,
                       symbol_value, number_value, begin_pos, end_pos,
                       " st %0d last %0b", lex_status, last_of_run);
          end
        end
      end
    end
    outstanding <= expected_tokens.size();
  end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: pattern tokenizer testbench
// feeds pattern bytes through a directed opening and random phases under
// several register settings and idling mixes, then ends the pattern; the
// token checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rpt_pkg::*;

  // pressure applied inside a phase
  localparam int PRESS_NONE  = 0;
  localparam int PRESS_HOLD  = 1;
  localparam int PRESS_DRAIN = 2;

  // ways the pattern can finish
  localparam int END_NUL      = 0;
  localparam int END_TRAIL    = 1;
  localparam int END_NONPRINT = 2;
  localparam int END_BADESC   = 3;

  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_BYTES  = 110;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic [7:0]  char_code = CH_NUL;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_IGNORE_BAD_ESC;
  logic        cfg_data = 1'b0;
  logic        token_stall = 1'b0;

  logic        char_stall;
  logic        cfg_ready;
  logic        token_valid;
  logic [4:0]  token_kind;
  logic [7:0]  symbol_value;
  logic [15:0] number_value;
  logic [15:0] begin_pos;
  logic [15:0] end_pos;
  logic [1:0]  lex_status;
  logic        last_of_run;

  int          mismatches;
  int          outstanding;

  // idling mix, percent of cycles
  int          idle_pct = 0;
  int          stall_pct = 0;

  // long receiver hold-off: requests from the stimulus, served by the stall process
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;

  // register values currently written, so stimulus never ends the pattern early
  logic        cur_ign = 1'b0;
  logic        cur_stray = 1'b0;
  logic        cur_skip = 1'b0;
  int          bytes_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  regex_pattern_tokenizer_unit dut (.*);

  rpt_token_checker token_check (.*);

  // receiver side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      token_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      token_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      token_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // one byte transaction, with random sender gaps in front of it
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // sender goes quiet until every predicted token has come out
  task automatic wait_drained();
    char_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // registers are only written with the block idle; a skipped byte leaves no
  // token behind, so the task also waits out the pipeline after the last one
  task automatic set_config(input logic ign, input logic str, input logic skp);
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin cfg_index <= CFG_IGNORE_BAD_ESC; cfg_data <= ign; end
        1: begin cfg_index <= CFG_STRAY_AS_ESC; cfg_data <= str; end
        default: begin cfg_index <= CFG_SKIP_NONPRINT; cfg_data <= skp; end
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_ign = ign;
    cur_stray = str;
    cur_skip = skp;
  endtask

  // any printable byte but the backslash, which would open an escape
  function automatic logic [7:0] printable_char();
    logic [7:0] c;
    c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    if (c == CH_BACKSLASH) c = CH_LOWER_S;
    return c;
  endfunction

  function automatic logic [7:0] operator_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = CH_STAR;
      1: c = CH_PLUS;
      2: c = CH_QUESTION;
      3: c = CH_BAR;
      4: c = CH_LPAREN;
      default: c = CH_RPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] escape_char();
    logic [7:0] c;
    case ($urandom_range(0, 16))
      0: c = CH_BACKSLASH;
      1: c = CH_LOWER_T;
      2: c = CH_LOWER_N;
      3: c = CH_LBRACKET;
      4: c = CH_RBRACKET;
      5: c = CH_LPAREN;
      6: c = CH_RPAREN;
      7: c = CH_LBRACE;
      8: c = CH_RBRACE;
      9: c = CH_STAR;
      10: c = CH_PLUS;
      11: c = CH_QUESTION;
      12: c = CH_BAR;
      13: c = CH_MINUS;
      14: c = CH_LOWER_S;
      15: c = CH_LOWER_D;
      default: c = CH_LOWER_W;
    endcase
    return c;
  endfunction

  // backslash plus one byte; unknown escapes only while they are just warnings,
  // and an escaped minus only where the block is surely in a bracket class
  task automatic send_escape(input logic in_class);
    logic [7:0] c;
    send_byte(CH_BACKSLASH);
    if (cur_ign && $urandom_range(0, 3) == 0) begin
      c = 8'($urandom_range(1, 255));
    end else begin
      c = escape_char();
      if (c == CH_MINUS && !in_class) c = CH_LOWER_W;
    end
    send_byte(c);
  endtask

  // mostly short numbers, now and then long enough to saturate
  task automatic send_number();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // one well-formed piece of pattern with random content, or a noise byte
  task automatic send_fragment();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // literal run; stray closers come up here too
      n = $urandom_range(1, 4);
      repeat (n) send_byte(printable_char());
    end else if (pick < 40) begin
      send_byte(operator_char());
    end else if (pick < 60) begin
      // bracket class: symbols, ranges with minus, escapes
      send_byte(CH_LBRACKET);
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: send_escape(1'b1);
          1: send_byte(CH_MINUS);
          default: begin
            c = printable_char();
            if (c == CH_RBRACKET) c = CH_LOWER_D;
            send_byte(c);
          end
        endcase
      end
      send_byte(CH_RBRACKET);
    end else if (pick < 80) begin
      // brace range, sometimes left open so the next byte falls back
      send_byte(CH_LBRACE);
      send_number();
      if ($urandom_range(0, 1) == 1) begin
        send_byte(CH_COMMA);
        if ($urandom_range(0, 1) == 1) send_number();
      end
      if ($urandom_range(0, 7) != 0) send_byte(CH_RBRACE);
      else send_byte(printable_char());
    end else if (pick < 92) begin
      send_escape(1'b0);
    end else begin
      // noise: anything but the end byte, nonprintable only while skipped
      c = 8'($urandom_range(1, 255));
      if (c == CH_BACKSLASH) send_escape(1'b0);
      else if ((c < CH_PRINT_LO || c > CH_PRINT_HI) && !cur_skip) send_byte(printable_char());
      else send_byte(c);
    end
  endtask

  task automatic run_phase(input logic ign, input logic str, input logic skp,
                           input int idle, input int stall, input int pressure);
    int   stop_at;
    logic paused;
    set_config(ign, str, skp);
    idle_pct = idle;
    stall_pct <= stall;
    // a hold-off while the sender keeps going fills the block up
    if (pressure == PRESS_HOLD) hold_requests <= hold_requests + 1;
    stop_at = bytes_sent + PHASE_BYTES;
    paused = 1'b0;
    while (bytes_sent < stop_at) begin
      send_fragment();
      if (pressure == PRESS_DRAIN && !paused && bytes_sent >= stop_at - PHASE_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    string      directed;
    int         finish_kind;
    int         mix;
    logic [7:0] c;
    // operators, a class with minus, escaped minus, class escape and stray
    // closers, stray closers outside, a saturating range, and a number
    // closed by a symbol that falls back to general lexing
    directed = "(*+?|)[-\\-)\\w{}]]}{65536,}{7x";

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed opening under reset settings, no warnings yet
    for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);

    run_phase(1'b0, 1'b0, 1'b0, 0, 0, PRESS_HOLD);
    run_phase(1'b1, 1'b0, 1'b0, 50, 0, PRESS_NONE);
    run_phase(1'b0, 1'b1, 1'b0, 0, 50, PRESS_HOLD);
    run_phase(1'b0, 1'b0, 1'b1, 31, 31, PRESS_DRAIN);
    run_phase(1'b1, 1'b1, 1'b1, 0, 0, PRESS_NONE);
    mix = $urandom_range(0, 3);
    case (mix)
      0: run_phase($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   0, 0, PRESS_DRAIN);
      1: run_phase($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   50, 0, PRESS_DRAIN);
      2: run_phase($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   0, 50, PRESS_DRAIN);
      default: run_phase($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         31, 31, PRESS_DRAIN);
    endcase

    // finish the pattern: end byte, trailing backslash, nonprintable byte or
    // unknown escape, the last three a warning or an error depending on the settings
    set_config($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    if ($urandom_range(0, 1) == 1) begin
      send_byte(CH_LBRACE);
      send_number();
    end
    finish_kind = $urandom_range(END_NUL, END_BADESC);
    case (finish_kind)
      END_NUL: send_byte(CH_NUL);
      END_TRAIL: begin
        send_byte(CH_BACKSLASH);
        send_byte(CH_NUL);
      end
      END_NONPRINT: begin
        c = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 31))
                                        : 8'($urandom_range(127, 255));
        send_byte(c);
        send_byte(CH_NUL);
      end
      default: begin
        send_byte(CH_BACKSLASH);
        send_byte(CH_LOWER_Q);
        send_byte(CH_NUL);
      end
    endcase

    // the block is halted now; these bytes must produce nothing
    repeat (8) send_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("regex_pattern_tokenizer_unit verification clean");
    end else begin
      $display("regex_pattern_tokenizer_unit verification failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("regex_pattern_tokenizer_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire

/* regex_pattern_tokenizer_unit.f */
hdl/rpt_pkg.sv
hdl/rpt_front.sv
hdl/rpt_queue.sv
hdl/rpt_back.sv
hdl/regex_pattern_tokenizer_unit.sv
bench/rpt_token_checker.sv
bench/tb_top.sv
